>>> src/vn_pkg.sv
// Shared constants for the 3D vector normalizer.
package vn_pkg;

    // Radicand is the sum of squares shifted up by this many bits,
    // which gives the magnitude MAG_FRAC fraction bits.
    localparam int RAD_SHIFT = 16;
    localparam int MAG_FRAC  = 8;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

endpackage

>>> src/vn_if.sv
// Item channels of the normalizer: input vector and normalized result.
interface vn_in_if #(
    parameter int IN_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vn_out_if #(
    parameter int OUT_FRAC = 14
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_FRAC+1:0] norm_x;
    logic signed [OUT_FRAC+1:0] norm_y;
    logic signed [OUT_FRAC+1:0] norm_z;
    logic                       zero_vector;

    modport source (output valid, norm_x, norm_y, norm_z, zero_vector, input ready);
    modport sink   (input valid, norm_x, norm_y, norm_z, zero_vector, output ready);
endinterface

>>> src/vector3_normalizer_top.sv
// Top level of the 3D vector normalizer.
// Takes one signed vector (x, y, z) per cycle while i_in.ready is high and
// returns its unit vector as signed Q1.OUT_FRAC components, truncated toward
// zero and clamped to +/-2^OUT_FRAC; an all-zero vector yields zero
// components with zero_vector set. Sustained rate is one vector per clock
// while the output is not stalled. The squares are registered at acceptance
// and the sum is written into the queue, then come one square-root stage per
// magnitude bit, one divider stage per quotient bit, and the output register.
// Back-pressure at the output stalls the back pipeline; a four-entry queue
// lets the front keep accepting meanwhile.
module vector3_normalizer_top #(
    parameter int IN_WIDTH = 16,
    parameter int OUT_FRAC = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vn_in_if.sink     i_in,
    vn_out_if.source  o_out
);
    import vn_pkg::*;

    localparam int ENT_W = 5 * IN_WIDTH + 1;

    logic             q_push, q_pop, q_full, q_empty;
    logic [ENT_W-1:0] q_wdata, q_rdata;

    vn_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    vn_queue #(.W(ENT_W)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wdata),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_rdata),
        .o_empty     (q_empty)
    );

    vn_back #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC(OUT_FRAC)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

>>> src/vn_front.sv
// Front end: accepts vectors, squares the components, forms the sum and zero flag.
module vn_front #(
    parameter int IN_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    vn_in_if.sink                           i_in,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output logic [5*IN_WIDTH:0]             o_q_data
);
    import vn_pkg::*;

    localparam int SUM_W = 2 * IN_WIDTH;

    logic                       r_v;
    logic signed [IN_WIDTH-1:0] r_x, r_y, r_z;
    logic [SUM_W-1:0]           r_sqx, r_sqy, r_sqz;
    logic                       n_v;
    logic                       load;
    logic [SUM_W-1:0]           sum;

    // Square stage holds one item; it frees when the queue takes it
    assign o_q_push   = r_v && !i_q_full;
    assign i_in.ready = !r_v || !i_q_full;
    assign load       = i_in.valid && i_in.ready;

    always_comb begin
        n_v = r_v;
        if (load) begin
            n_v = 1'b1;
        end else if (o_q_push) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    // Squares are non-negative, kept as unsigned bits
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x   <= i_in.vec_x;
            r_y   <= i_in.vec_y;
            r_z   <= i_in.vec_z;
            r_sqx <= $unsigned(SUM_W'(i_in.vec_x) * SUM_W'(i_in.vec_x));
            r_sqy <= $unsigned(SUM_W'(i_in.vec_y) * SUM_W'(i_in.vec_y));
            r_sqz <= $unsigned(SUM_W'(i_in.vec_z) * SUM_W'(i_in.vec_z));
        end
    end

    // Sum of three squares stays below 2^SUM_W
    assign sum      = r_sqx + r_sqy + r_sqz;
    assign o_q_data = {r_x, r_y, r_z, sum, (sum == '0)};

endmodule

>>> src/vn_queue.sv
// Short item queue decoupling the front end from the back end.
module vn_queue #(
    parameter int W = 65
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_pop_data,
    output logic         o_empty
);
    import vn_pkg::*;

    logic [W-1:0]      r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full     = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/vn_back.sv
// Back end: pipelined square root, three pipelined dividers, sign and clamp.
module vn_back #(
    parameter int IN_WIDTH = 16,
    parameter int OUT_FRAC = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [5*IN_WIDTH:0] i_q_data,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    vn_out_if.source            o_out
);
    import vn_pkg::*;

    localparam int SUM_W   = 2 * IN_WIDTH;
    localparam int RAD_W   = SUM_W + RAD_SHIFT;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int QB      = OUT_FRAC + 1;
    localparam int OUT_W   = OUT_FRAC + 2;
    localparam int DIV_PRE = OUT_FRAC + MAG_FRAC - QB;

    typedef struct packed {
        logic                              v;
        logic                              zero;
        logic [2:0][IN_WIDTH-1:0]          c;
        logic [RAD_W-1:0]                  rem;
        logic [ROOT_W-1:0]                 root;
    } t_sq;

    typedef struct packed {
        logic                              v;
        logic                              zero;
        logic [2:0]                        neg;
        logic [ROOT_W-1:0]                 mq;
        logic [2:0][ROOT_W-1:0]            rem;
        logic [2:0][QB-1:0]                q;
    } t_dv;

    logic              en;
    t_sq               sq_head;
    t_dv               dv_head;
    t_sq               r_sq [ROOT_W];
    t_dv               r_dv [QB];
    logic              r_ov;
    logic [2:0][OUT_W-1:0] r_on;
    logic              r_oz;

    // Whole back pipeline advances when the output register can take an item
    assign en      = !r_ov || o_out.ready;
    assign o_q_pop = en && !i_q_empty;

    // Queue head enters the root pipeline; remainder starts as the radicand
    always_comb begin
        sq_head      = '0;
        sq_head.v    = !i_q_empty;
        sq_head.zero = i_q_data[0];
        sq_head.c    = i_q_data[5*IN_WIDTH -: 3*IN_WIDTH];
        sq_head.rem  = {i_q_data[SUM_W:1], {RAD_SHIFT{1'b0}}};
        sq_head.root = '0;
    end

    // One root bit per stage, most significant first
    for (genvar s = 0; s < ROOT_W; s++) begin : g_sq
        localparam int K = ROOT_W - 1 - s;
        t_sq        prev;
        t_sq        nxt;
        logic [RAD_W:0] delta;
        logic       take;

        if (s == 0) begin : g_first
            assign prev = sq_head;
        end else begin : g_next
            assign prev = r_sq[s-1];
        end

        // (root + 2^K)^2 - root^2
        assign delta = ((RAD_W+1)'(prev.root) << (K + 1)) + ((RAD_W+1)'(1) << (2 * K));
        assign take  = ((RAD_W+1)'(prev.rem) >= delta);

        always_comb begin
            nxt = prev;
            if (take) begin
                nxt.rem  = prev.rem - delta[RAD_W-1:0];
                nxt.root = prev.root | (ROOT_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[s].v <= 1'b0;
            end else if (en) begin
                r_sq[s] <= nxt;
            end
        end
    end

    // Magnitude and component signs enter the dividers; remainder preloaded with |component| << DIV_PRE
    always_comb begin
        dv_head      = '0;
        dv_head.v    = r_sq[ROOT_W-1].v;
        dv_head.zero = r_sq[ROOT_W-1].zero;
        dv_head.mq   = r_sq[ROOT_W-1].root;
        for (int i = 0; i < 3; i++) begin
            dv_head.neg[i] = r_sq[ROOT_W-1].c[i][IN_WIDTH-1];
            dv_head.rem[i] = ROOT_W'(IN_WIDTH'(dv_head.neg[i] ? (~r_sq[ROOT_W-1].c[i] + 1'b1)
                                                              : r_sq[ROOT_W-1].c[i]))
                             << DIV_PRE;
        end
    end

    // One quotient bit per stage for each lane
    for (genvar j = 0; j < QB; j++) begin : g_dv
        t_dv prev;
        t_dv nxt;

        if (j == 0) begin : g_first
            assign prev = dv_head;
        end else begin : g_next
            assign prev = r_dv[j-1];
        end

        always_comb begin
            logic [ROOT_W:0] t;
            logic            ge;
            nxt = prev;
            for (int i = 0; i < 3; i++) begin
                t  = {prev.rem[i], 1'b0};
                ge = (t >= (ROOT_W+1)'(prev.mq));
                nxt.rem[i] = ge ? ROOT_W'(t - (ROOT_W+1)'(prev.mq)) : t[ROOT_W-1:0];
                nxt.q[i]   = {prev.q[i][QB-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j].v <= 1'b0;
            end else if (en) begin
                r_dv[j] <= nxt;
            end
        end
    end

    // Clamp, restore sign, force zero for a zero vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QB-1].v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [QB-1:0]    qc;
        logic [OUT_W-1:0] qe;
        if (en) begin
            r_oz <= r_dv[QB-1].zero;
            for (int i = 0; i < 3; i++) begin
                qc = (r_dv[QB-1].q[i] > (QB'(1) << OUT_FRAC)) ? (QB'(1) << OUT_FRAC)
                                                              : r_dv[QB-1].q[i];
                qe = OUT_W'(qc);
                if (r_dv[QB-1].zero) begin
                    r_on[i] <= '0;
                end else if (r_dv[QB-1].neg[i]) begin
                    r_on[i] <= ~qe + 1'b1;
                end else begin
                    r_on[i] <= qe;
                end
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.norm_x      = $signed(r_on[2]);
    assign o_out.norm_y      = $signed(r_on[1]);
    assign o_out.norm_z      = $signed(r_on[0]);
    assign o_out.zero_vector = r_oz;

endmodule
